### design/bank_switch_mapper_with_scanline_irq_assert.svh
// Assertion macros for the bank switch mapper.
// Included by the RTL files that check themselves; needs nothing else.
`ifndef BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_ASSERT_SVH
`define BANK_SWITCH_MAPPER_WITH_SCANLINE_IRQ_ASSERT_SVH

`ifndef SYNTHESIS

// Checked outside reset.
`define BSM_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define BSM_ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define BSM_ASSERT(lbl, clock, reset, prop, msg)
`define BSM_ASSERT_ALWAYS(lbl, clock, prop, msg)

`endif

`endif

### design/bsm_pkg.sv
// Shared types and constants for the bank switch mapper.
// No dependencies.
`default_nettype none

package bsm_pkg;

  localparam int unsigned NUM_BANK_REGS = 8;

  typedef logic [7:0] bank_t;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_PRG      = 2'd1,
    REQ_CHR      = 2'd2,
    REQ_SCANLINE = 2'd3
  } req_t;

  // Register write decode: {address[15:13], address[0]}
  typedef enum logic [3:0] {
    WR_BANK_SELECT = 4'b1000,
    WR_BANK_DATA   = 4'b1001,
    WR_MIRROR      = 4'b1010,
    WR_PROTECT     = 4'b1011,
    WR_IRQ_LATCH   = 4'b1100,
    WR_IRQ_RELOAD  = 4'b1101,
    WR_IRQ_DISABLE = 4'b1110,
    WR_IRQ_ENABLE  = 4'b1111
  } wr_code_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PRG_MASK     = 2'd0,
    CFG_CHR_MASK     = 2'd1,
    CFG_FOUR_SCREEN  = 2'd2,
    CFG_PROTECT_IGN  = 2'd3
  } cfg_idx_t;

  // RAM protect mode, data bits 7..6
  localparam logic [1:0] PROT_BOTH_ON  = 2'b10;
  localparam logic [1:0] PROT_READ_ONLY = 2'b11;

  localparam bank_t PRG_MASK_RESET = 8'd63;
  localparam bank_t CHR_MASK_RESET = 8'd255;
  localparam bank_t PRG_SECOND_LAST = 8'hFE;
  localparam bank_t PRG_LAST        = 8'hFF;

  localparam bank_t BANK_REGS_INIT [NUM_BANK_REGS] = '{
    8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1
  };

  typedef struct packed {
    logic [20:0] mapped_addr;
    logic        mirror_horizontal;
    logic        ram_read_enable;
    logic        ram_write_enable;
    logic        irq_pending;
  } result_t;

endpackage

`default_nettype wire

### design/bank_switch_mapper_with_scanline_irq.sv
// Top level of the bank switch mapper with scanline IRQ counter.
// Uses bsm_pkg and the assertion macros in bank_switch_mapper_with_scanline_irq_assert.svh.
`default_nettype none
`include "bank_switch_mapper_with_scanline_irq_assert.svh"

// Bank switch mapper (MMC3 style, NEC counter behavior). Every input beat is a
// register write, a program lookup, a pattern lookup or a scanline clock, and
// gives exactly one result beat carrying the mapped ROM offset (zero for
// writes and clocks) together with mirroring, RAM enables and the IRQ line as
// they stand after that beat. One beat is taken every clock while in_stall is
// low; the result is held in the output register. The decode, the bank
// selection and the counter step all sit in the single combinational stage
// between the input ports and that register. A skid register behind the
// output lets one more beat in while a result waits; in_stall rises only when
// the skid register is full. Configuration writes are always ready and must
// come while the block is idle.
module bank_switch_mapper_with_scanline_irq import bsm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  data,
  // result channel
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [20:0] mapped_addr,
  output      logic        mirror_horizontal,
  output      logic        ram_read_enable,
  output      logic        ram_write_enable,
  output      logic        irq_pending,
  // configuration channel
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  bank_t prg_bank_mask;
  bank_t chr_bank_mask;
  logic  four_screen;
  logic  ram_protect_ignored;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_mask       <= PRG_MASK_RESET;
      chr_bank_mask       <= CHR_MASK_RESET;
      four_screen         <= 1'b0;
      ram_protect_ignored <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PRG_MASK:    prg_bank_mask       <= cfg_data;
        CFG_CHR_MASK:    chr_bank_mask       <= cfg_data;
        CFG_FOUR_SCREEN: four_screen         <= cfg_data[0];
        CFG_PROTECT_IGN: ram_protect_ignored <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Mapper state
  // ---------------------------------------------------------------------------
  bank_t bank_select, bank_select_next;
  bank_t bank_regs [NUM_BANK_REGS];
  logic  bank_wr;
  logic  mirror_reg, mirror_reg_next;
  logic  ram_read_flag, ram_read_flag_next;
  logic  ram_write_flag, ram_write_flag_next;
  bank_t irq_latch, irq_latch_next;
  bank_t irq_counter, irq_counter_next;
  logic  irq_enable, irq_enable_next;
  logic  irq_flag, irq_flag_next;

  logic    accept;
  req_t    req;
  logic [3:0] wr_code;

  assign accept  = in_valid && !in_stall;
  assign req     = req_t'(req_type);
  assign wr_code = {address[15:13], address[0]};

  // State update: writes and scanline clocks
  always_comb begin
    bank_select_next    = bank_select;
    bank_wr             = 1'b0;
    mirror_reg_next     = mirror_reg;
    ram_read_flag_next  = ram_read_flag;
    ram_write_flag_next = ram_write_flag;
    irq_latch_next      = irq_latch;
    irq_counter_next    = irq_counter;
    irq_enable_next     = irq_enable;
    irq_flag_next       = irq_flag;

    unique case (req)
      REQ_WRITE: begin
        unique case (wr_code)
          WR_BANK_SELECT: bank_select_next = data;
          WR_BANK_DATA:   bank_wr = 1'b1;
          WR_MIRROR: begin
            if (!four_screen) begin
              mirror_reg_next = data[0];
            end
          end
          WR_PROTECT: begin
            if (!ram_protect_ignored) begin
              ram_read_flag_next  = (data[7:6] == PROT_BOTH_ON) ||
                                    (data[7:6] == PROT_READ_ONLY);
              ram_write_flag_next = (data[7:6] == PROT_BOTH_ON);
            end
          end
          WR_IRQ_LATCH:  irq_latch_next = data;
          WR_IRQ_RELOAD: irq_counter_next = '0;
          WR_IRQ_DISABLE: begin
            irq_enable_next = 1'b0;
            irq_flag_next   = 1'b0;
          end
          WR_IRQ_ENABLE: irq_enable_next = 1'b1;
          default: ;  // below 0x8000: no register
        endcase
      end
      REQ_SCANLINE: begin
        // reload at zero, else count down; flag when it lands on zero
        if (irq_counter == '0) begin
          irq_counter_next = irq_latch;
        end else begin
          irq_counter_next = irq_counter - 8'd1;
        end
        if ((irq_counter_next == '0) && irq_enable) begin
          irq_flag_next = 1'b1;
        end
      end
      default: ;  // lookups leave the state alone
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select    <= '0;
      bank_regs      <= BANK_REGS_INIT;
      mirror_reg     <= 1'b0;
      ram_read_flag  <= 1'b1;
      ram_write_flag <= 1'b1;
      irq_latch      <= '0;
      irq_counter    <= '0;
      irq_enable     <= 1'b0;
      irq_flag       <= 1'b0;
    end else if (accept) begin
      bank_select    <= bank_select_next;
      if (bank_wr) begin
        bank_regs[bank_select[2:0]] <= data;
      end
      mirror_reg     <= mirror_reg_next;
      ram_read_flag  <= ram_read_flag_next;
      ram_write_flag <= ram_write_flag_next;
      irq_latch      <= irq_latch_next;
      irq_counter    <= irq_counter_next;
      irq_enable     <= irq_enable_next;
      irq_flag       <= irq_flag_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Bank lookups
  // ---------------------------------------------------------------------------
  bank_t      prg_bank;
  bank_t      chr_bank;
  logic [2:0] chr_slot;

  // bank_select bit 6 swaps R6 with the fixed second-last bank
  always_comb begin
    unique case (address[14:13])
      2'd0:    prg_bank = bank_select[6] ? PRG_SECOND_LAST : bank_regs[6];
      2'd1:    prg_bank = bank_regs[7];
      2'd2:    prg_bank = bank_select[6] ? bank_regs[6] : PRG_SECOND_LAST;
      default: prg_bank = PRG_LAST;
    endcase
  end

  // bank_select bit 7 swaps the two 4K pattern halves
  assign chr_slot = address[12:10] ^ {bank_select[7], 2'b00};

  always_comb begin
    unique case (chr_slot)
      3'd0:    chr_bank = {bank_regs[0][7:1], 1'b0};
      3'd1:    chr_bank = {bank_regs[0][7:1], 1'b1};
      3'd2:    chr_bank = {bank_regs[1][7:1], 1'b0};
      3'd3:    chr_bank = {bank_regs[1][7:1], 1'b1};
      3'd4:    chr_bank = bank_regs[2];
      3'd5:    chr_bank = bank_regs[3];
      3'd6:    chr_bank = bank_regs[4];
      default: chr_bank = bank_regs[5];
    endcase
  end

  result_t res;

  always_comb begin
    unique case (req)
      REQ_PRG: res.mapped_addr = {prg_bank & prg_bank_mask, address[12:0]};
      REQ_CHR: res.mapped_addr = {3'b000, chr_bank & chr_bank_mask, address[9:0]};
      default: res.mapped_addr = '0;
    endcase
    res.mirror_horizontal = mirror_reg_next;
    res.ram_read_enable   = ram_read_flag_next;
    res.ram_write_enable  = ram_write_flag_next;
    res.irq_pending       = irq_flag_next;
  end

  // ---------------------------------------------------------------------------
  // Output register with skid stage
  // ---------------------------------------------------------------------------
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  logic    out_free;

  assign in_stall = skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res;
      end
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign mapped_addr       = out_res.mapped_addr;
  assign mirror_horizontal = out_res.mirror_horizontal;
  assign ram_read_enable   = out_res.ram_read_enable;
  assign ram_write_enable  = out_res.ram_write_enable;
  assign irq_pending       = out_res.irq_pending;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `BSM_ASSERT(a_skid_behind_out, clk, rst, skid_valid |-> out_valid,
              "skid register holds a beat while the output register is empty")
  `BSM_ASSERT_ALWAYS(a_write_needs_read, clk, ram_write_flag |-> ram_read_flag,
                     "RAM writes enabled with reads disabled")
  `BSM_ASSERT(a_irq_rise_on_clock, clk, rst,
              $rose(irq_flag) |-> $past(accept && (req == REQ_SCANLINE)),
              "IRQ raised without a scanline clock")
  `BSM_ASSERT(a_irq_fall_on_disable, clk, rst,
              $fell(irq_flag) |-> ($past(rst) ||
                $past(accept && (req == REQ_WRITE) && (wr_code == WR_IRQ_DISABLE))),
              "IRQ cleared without a disable write")

endmodule

`default_nettype wire
